/* rtl/mlbs_pkg.sv */
// shared types and register indexes for the median lux backlight selector
`timescale 1ns / 1ps

package mlbs_pkg;

	typedef enum logic [1:0] {
		MODE_DAY   = 2'd0,
		MODE_DUSK  = 2'd1,
		MODE_NIGHT = 2'd2
	} mode_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned LUX_W      = 16;
	localparam int unsigned LEVEL_W    = 8;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_DAY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_DUSK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DAY      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DUSK     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_NIGHT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_PRESENT = 3'd5;

endpackage

/* rtl/median_lux_backlight_selector.sv */
// median lux backlight selector: sliding-window median and day/dusk/night mode pick
`timescale 1ns / 1ps

// Each lux request on the s_axis side is captured in an input register, written into a ring
// of WINDOW samples (zero after reset) and the median (rank WINDOW/2) of the ring is found by
// a combinational rank count, then compared against the day and dusk thresholds; the result
// (mode, brightness of that mode, changed flag, median) sits in an output register on the
// m_axis side. Throughput is one request per cycle unless m_axis_tready stalls the output;
// each request passes the input and output registers. The rank-count compare array over all
// WINDOW entries sets the cycle time. With sensor_present clear the sample is dropped and the
// mode goes to day. Configuration writes must only be issued while the block is empty.
module median_lux_backlight_selector
	import mlbs_pkg::*;
#(
	parameter int unsigned WINDOW = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,  // [15:0] lux_sample
	// output stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [31:0]           m_axis_tdata   // [1:0] mode, [9:2] brightness,
	                                             // [10] changed, [26:11] median_lux, rest 0
);

	localparam int unsigned POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
	localparam int unsigned RANK   = WINDOW / 2;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW - 1);

	// configuration registers
	logic [LUX_W-1:0]   threshold_day_q;
	logic [LUX_W-1:0]   threshold_dusk_q;
	logic [LEVEL_W-1:0] level_day_q;
	logic [LEVEL_W-1:0] level_dusk_q;
	logic [LEVEL_W-1:0] level_night_q;
	logic               sensor_present_q;

	// window state
	logic [LUX_W-1:0] window_q [WINDOW];
	logic [POS_W-1:0] wr_pos_q;
	mode_t            cur_mode_q;

	// pipeline
	logic             valid_s1;
	logic [LUX_W-1:0] lux_s1;
	logic             valid_s2;
	mode_t            mode_s2;
	logic [LEVEL_W-1:0] bright_s2;
	logic             changed_s2;
	logic [LUX_W-1:0] median_s2;

	logic             advance;
	logic [LUX_W-1:0] win_next [WINDOW];
	logic [LUX_W-1:0] median;
	mode_t            new_mode;
	logic [LEVEL_W-1:0] new_level;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_day_q  <= 16'd200;
			threshold_dusk_q <= 16'd50;
			level_day_q      <= 8'd255;
			level_dusk_q     <= 8'd128;
			level_night_q    <= 8'd40;
			sensor_present_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_THRESHOLD_DAY:  threshold_day_q  <= cfg_data;
				REG_THRESHOLD_DUSK: threshold_dusk_q <= cfg_data;
				REG_LEVEL_DAY:      level_day_q      <= cfg_data[LEVEL_W-1:0];
				REG_LEVEL_DUSK:     level_dusk_q     <= cfg_data[LEVEL_W-1:0];
				REG_LEVEL_NIGHT:    level_night_q    <= cfg_data[LEVEL_W-1:0];
				REG_SENSOR_PRESENT: sensor_present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// window with the stage-one sample placed
	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			win_next[i] = window_q[i];
			if (sensor_present_q && (wr_pos_q == POS_W'(i))) begin
				win_next[i] = lux_s1;
			end
		end
	end

	// rank-count median, first entry holding the rank wins
	always_comb begin
		logic [CNT_W-1:0] below;
		logic [CNT_W-1:0] not_above;
		logic             found;
		median = '0;
		found  = 1'b0;
		for (int i = 0; i < WINDOW; i++) begin
			below     = '0;
			not_above = '0;
			for (int j = 0; j < WINDOW; j++) begin
				below     = below + CNT_W'(win_next[j] < win_next[i]);
				not_above = not_above + CNT_W'(win_next[j] <= win_next[i]);
			end
			if (!found && (below <= CNT_W'(RANK)) && (CNT_W'(RANK) < not_above)) begin
				median = win_next[i];
				found  = 1'b1;
			end
		end
	end

	always_comb begin
		if (!sensor_present_q) begin
			new_mode = MODE_DAY;
		end else if (median >= threshold_day_q) begin
			new_mode = MODE_DAY;
		end else if (median >= threshold_dusk_q) begin
			new_mode = MODE_DUSK;
		end else begin
			new_mode = MODE_NIGHT;
		end
		case (new_mode)
			MODE_DAY:  new_level = level_day_q;
			MODE_DUSK: new_level = level_dusk_q;
			default:   new_level = level_night_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			wr_pos_q   <= '0;
			cur_mode_q <= MODE_DAY;
			for (int i = 0; i < WINDOW; i++) begin
				window_q[i] <= '0;
			end
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2   <= 1'b1;
				cur_mode_q <= new_mode;
				for (int i = 0; i < WINDOW; i++) begin
					window_q[i] <= win_next[i];
				end
				if (sensor_present_q) begin
					wr_pos_q <= (wr_pos_q >= LAST_POS) ? '0 : wr_pos_q + 1'b1;
				end
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			lux_s1 <= s_axis_tdata;
		end
		if (advance) begin
			mode_s2    <= new_mode;
			bright_s2  <= new_level;
			changed_s2 <= (new_mode != cur_mode_q);
			median_s2  <= median;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'd0, median_s2, changed_s2, bright_s2, mode_s2};

	// ring position stays inside the window
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pos_q <= LAST_POS)
		else $error("write position out of range");

	// changed flag matches a real mode transition
	a_changed: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (changed_s2 == (mode_s2 != $past(cur_mode_q))))
		else $error("changed flag does not match mode transition");

	// absent sensor forces day and freezes the ring
	a_no_sensor: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !sensor_present_q) |=> (mode_s2 == MODE_DAY) && $stable(wr_pos_q))
		else $error("absent sensor did not force day or moved the ring");

	// a pending result always shows the stored mode
	a_mode_sync: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (mode_s2 == cur_mode_q))
		else $error("pending result mode differs from stored mode");

endmodule

/* tb/tb_median_lux_backlight_selector.sv */
// self-checking testbench for the median lux backlight selector stream block
`timescale 1ns / 1ps

module tb_median_lux_backlight_selector;
	import mlbs_pkg::*;

	localparam int unsigned WIN = 5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		mode_t                mode;
		logic [LEVEL_W-1:0]   brightness;
		logic                 changed;
		logic [LUX_W-1:0]     median_lux;
	} backlight_result_t;

	class backlight_checker;
		logic [LUX_W-1:0]   thr_day;
		logic [LUX_W-1:0]   thr_dusk;
		logic [LEVEL_W-1:0] lvl_day;
		logic [LEVEL_W-1:0] lvl_dusk;
		logic [LEVEL_W-1:0] lvl_night;
		logic               sensor_on;
		logic [LUX_W-1:0]   ring [WIN];
		int unsigned        wr_pos;
		mode_t              cur_mode;
		backlight_result_t  awaited_results [$];
		int unsigned        errors;
		int unsigned        results_seen;

		function new();
			thr_day = 16'd200;
			thr_dusk = 16'd50;
			lvl_day = 8'd255;
			lvl_dusk = 8'd128;
			lvl_night = 8'd40;
			sensor_on = 1'b1;
			foreach (ring[i]) ring[i] = '0;
			wr_pos = 0;
			cur_mode = MODE_DAY;
			errors = 0;
			results_seen = 0;
		endfunction

		function int unsigned pending();
			return awaited_results.size();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_THRESHOLD_DAY: thr_day = data;
				REG_THRESHOLD_DUSK: thr_dusk = data;
				REG_LEVEL_DAY: lvl_day = data[LEVEL_W-1:0];
				REG_LEVEL_DUSK: lvl_dusk = data[LEVEL_W-1:0];
				REG_LEVEL_NIGHT: lvl_night = data[LEVEL_W-1:0];
				REG_SENSOR_PRESENT: sensor_on = data[0];
				default: ;
			endcase
		endfunction

		// sorted copy of the ring, middle element
		function logic [LUX_W-1:0] ring_median();
			logic [LUX_W-1:0] sorted [WIN];
			logic [LUX_W-1:0] tmp;
			foreach (ring[i]) sorted[i] = ring[i];
			for (int i = 1; i < WIN; i++) begin
				for (int j = i; j > 0 && sorted[j-1] > sorted[j]; j--) begin
					tmp = sorted[j];
					sorted[j] = sorted[j-1];
					sorted[j-1] = tmp;
				end
			end
			return sorted[WIN/2];
		endfunction

		function void note_sample(logic [LUX_W-1:0] lux);
			backlight_result_t r;
			mode_t next_mode;
			logic [LUX_W-1:0] med;
			if (sensor_on) begin
				ring[wr_pos] = lux;
				wr_pos = (wr_pos + 1) % WIN;
			end
			med = ring_median();
			if (!sensor_on)
				next_mode = MODE_DAY;
			else if (med >= thr_day)
				next_mode = MODE_DAY;
			else if (med >= thr_dusk)
				next_mode = MODE_DUSK;
			else
				next_mode = MODE_NIGHT;
			r.changed = (next_mode != cur_mode);
			cur_mode = next_mode;
			r.mode = next_mode;
			case (next_mode)
				MODE_DAY: r.brightness = lvl_day;
				MODE_DUSK: r.brightness = lvl_dusk;
				default: r.brightness = lvl_night;
			endcase
			r.median_lux = med;
			awaited_results.push_back(r);
		endfunction

		task report(string field, logic [31:0] want, logic [31:0] got);
			$display("result %0d: %s expected %0h got %0h", results_seen, field, want, got);
			errors++;
		endtask

		task check_result(logic [31:0] word);
			backlight_result_t want;
			results_seen++;
			if (awaited_results.size() == 0) begin
				report("unexpected result", 32'd0, word);
				return;
			end
			want = awaited_results.pop_front();
			if (word[1:0] !== want.mode)
				report("mode", 32'(want.mode), 32'(word[1:0]));
			if (word[9:2] !== want.brightness)
				report("brightness", 32'(want.brightness), 32'(word[9:2]));
			if (word[10] !== want.changed)
				report("changed", 32'(want.changed), 32'(word[10]));
			if (word[26:11] !== want.median_lux)
				report("median_lux", 32'(want.median_lux), 32'(word[26:11]));
			if (word[31:27] !== 5'd0)
				report("padding", 32'd0, 32'(word[31:27]));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata;   // [15:0] lux_sample
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [31:0]           m_axis_tdata;   // [1:0] mode, [9:2] brightness, [10] changed,
	                                       // [26:11] median_lux, rest 0

	backlight_checker sb;
	bit               quiet;
	int               band;
	int               rx_wait;
	logic             rx_ready_next;

	median_lux_backlight_selector #(
		.WINDOW(WIN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL median_lux_backlight_selector");
		$finish;
	end

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 14);
	endfunction

	// result side: random stall before each result
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_wait = 0;
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata);
				rx_wait = draw_gap();
			end
			if (rx_wait > 0) begin
				rx_wait--;
				rx_ready_next = 1'b0;
			end else begin
				rx_ready_next = 1'b1;
			end
			m_axis_tready <= rx_ready_next;
		end
	end

	task automatic send_lux(logic [15:0] lux);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= lux;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_sample(lux);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic cfg_done();
		cfg_valid <= 1'b0;
	endtask

	// level writes carry random upper bits that must be dropped
	task automatic write_level(logic [CFG_IDX_W-1:0] idx, logic [7:0] lvl);
		logic [7:0] junk;
		junk = 8'($urandom);
		write_reg(idx, {junk, lvl});
	endtask

	task automatic write_sensor(logic on);
		logic [14:0] junk;
		junk = 15'($urandom);
		write_reg(REG_SENSOR_PRESENT, {junk, on});
	endtask

	// samples cluster around the thresholds so that all modes and changes occur
	function automatic logic [15:0] pick_lux();
		int base;
		int v;
		if ($urandom_range(0, 7) == 0)
			band = $urandom_range(0, 4);
		case (band)
			0: base = int'(sb.thr_day);
			1: base = (int'(sb.thr_day) + int'(sb.thr_dusk)) / 2;
			2: base = int'(sb.thr_dusk);
			3: base = $urandom_range(0, 64);
			default: return 16'($urandom);
		endcase
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom);
		v = base + $urandom_range(0, 20) - 10;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	logic [15:0] boundary_lux [19] = '{
		16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd199, 16'd199, 16'd199,
		16'd200, 16'd200, 16'd200, 16'd50, 16'd50, 16'd50, 16'd49, 16'd49,
		16'd49, 16'd0, 16'd0, 16'd0
	};

	initial begin
		logic [15:0] a;
		logic [15:0] b;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		quiet = 1'b0;
		band = 0;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// threshold edges with reset settings, zeros still in the window
		foreach (boundary_lux[i]) send_lux(boundary_lux[i]);
		wait_drained();

		// sensor absent: samples dropped, mode forced to day
		write_sensor(1'b0);
		cfg_done();
		send_lux(16'hffff);
		send_lux(16'h0000);
		wait_drained();

		// dusk threshold above day threshold
		write_sensor(1'b1);
		write_reg(REG_THRESHOLD_DAY, 16'd100);
		write_reg(REG_THRESHOLD_DUSK, 16'd1000);
		cfg_done();
		repeat (3) send_lux(16'd500);
		repeat (3) send_lux(16'd20);

		for (int p = 0; p < 10; p++) begin
			wait_drained();
			quiet = (p % 3 == 2);
			case (p)
				0: begin a = 16'hffff; b = 16'hffff; end
				1: begin a = 16'h0000; b = 16'h0000; end
				2: begin a = 16'h1000; b = 16'hf000; end
				3: begin a = 16'hffff; b = 16'h0000; end
				default: begin
					a = 16'($urandom);
					b = 16'($urandom);
					if ((a < b) != (p == 7)) begin
						a = a ^ b;
						b = a ^ b;
						a = a ^ b;
					end
				end
			endcase
			write_reg(REG_THRESHOLD_DAY, a);
			write_reg(REG_THRESHOLD_DUSK, b);
			case (p)
				0: begin
					write_level(REG_LEVEL_DAY, 8'd0);
					write_level(REG_LEVEL_DUSK, 8'd0);
					write_level(REG_LEVEL_NIGHT, 8'd0);
				end
				1: begin
					write_level(REG_LEVEL_DAY, 8'd255);
					write_level(REG_LEVEL_DUSK, 8'd255);
					write_level(REG_LEVEL_NIGHT, 8'd255);
				end
				default: begin
					write_level(REG_LEVEL_DAY, 8'($urandom));
					write_level(REG_LEVEL_DUSK, 8'($urandom));
					write_level(REG_LEVEL_NIGHT, 8'($urandom));
				end
			endcase
			write_reg((p % 2 == 0) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
			if (p % 3 == 1) begin
				write_sensor(1'b0);
				cfg_done();
				repeat (12) send_lux(pick_lux());
				wait_drained();
			end
			write_sensor(1'b1);
			cfg_done();
			band = $urandom_range(0, 4);
			repeat (105) begin
				send_lux(pick_lux());
				if ($urandom_range(0, 63) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS median_lux_backlight_selector");
		else
			$display("FAIL median_lux_backlight_selector");
		$finish;
	end

endmodule

/* median_lux_backlight_selector.f */
rtl/mlbs_pkg.sv
rtl/median_lux_backlight_selector.sv
tb/tb_median_lux_backlight_selector.sv
